[rtl/core/kbh_pkg.sv]
package kbh_pkg;

  localparam int MAX_KMER_LENGTH = 32;
  localparam int VAL_W = 64;
  localparam int HALF_W = VAL_W / 2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_KMER_LEN = 3'd0;
  localparam logic [2:0] REG_PFX_LEN  = 3'd1;
  localparam logic [2:0] REG_COEFF    = 3'd2;
  localparam logic [2:0] REG_KEY      = 3'd3;

  localparam logic ACT_FORWARD = 1'b0;
  localparam logic ACT_INVERSE = 1'b1;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [5:0]       k;      // saturated base count
    logic [6:0]       sh;     // suffix width in bits, 2*(k-p)
    logic [VAL_W-1:0] full;   // mask of 2k bits
    logic [VAL_W-1:0] key;    // key, already masked
    logic [VAL_W-1:0] coeff;  // odd multiplier
    logic [VAL_W-1:0] inv;    // its inverse mod 2^64
  } kbh_cfg_t;

  typedef enum logic [1:0] {
    INV_IDLE = 2'b01,
    INV_RUN  = 2'b10
  } kbh_inv_state_t;

  function automatic logic [VAL_W-1:0] low_mask(input logic [6:0] n);
    logic [VAL_W-1:0] m;
    if (n >= 7'(VAL_W)) m = '1;
    else m = (VAL_W'(1) << n) - VAL_W'(1);
    return m;
  endfunction

  function automatic logic [VAL_W-1:0] swap_halves(input logic [VAL_W-1:0] s,
                                                   input logic [5:0] k,
                                                   input logic [VAL_W-1:0] full);
    logic [VAL_W-1:0] half;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    half = low_mask({1'b0, k});
    lo = s & half;
    hi = (s >> k) & half;
    return ((lo << k) | hi) & full;
  endfunction

endpackage

[rtl/core/kmer_bijective_hash.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_action, in_value
// out_      output     out_valid / out_stall out_result, out_prefix_part, out_suffix_part
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle unless out_stall or a busy inverse unit holds the input, through
// four register stages (operand, partial products, sum, output), sized by the 64-bit
// product done as three 32x32 partial products. A coefficient write starts the inverse
// unit (4 Newton steps, 2 products each), cfg_ready low and in_stall high meanwhile.
// Reset: k=31, prefix=10, coeff=1, inverse=1, key=0, pipeline empty.
// out_stall on a valid result freezes the whole pipeline; nothing is dropped or repeated.
module kmer_bijective_hash import kbh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_result,
  output logic [VAL_W-1:0] out_prefix_part,
  output logic [VAL_W-1:0] out_suffix_part,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [VAL_W-1:0] cfg_data
);

  logic [5:0]       kmer_len_r;
  logic [5:0]       pfx_len_r;
  logic [VAL_W-1:0] coeff_r;
  logic [VAL_W-1:0] key_r;

  logic             inv_busy;
  logic [VAL_W-1:0] inv_coeff;
  logic             cfg_wr;
  logic [VAL_W-1:0] coeff_nxt;

  logic [5:0] k_eff, p_eff;
  kbh_cfg_t   cfg;

  assign cfg_ready = !inv_busy;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign coeff_nxt = cfg_data | VAL_W'(1);   // coefficient is always odd

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= 6'd31;
      pfx_len_r <= 6'd10;
      coeff_r <= VAL_W'(1);
      key_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_KMER_LEN: kmer_len_r <= cfg_data[5:0];
        REG_PFX_LEN:  pfx_len_r <= cfg_data[5:0];
        REG_COEFF:    coeff_r <= coeff_nxt;
        REG_KEY:      key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate k into 1..max, prefix into 0..k
  always_comb begin
    if (kmer_len_r == 6'd0) k_eff = 6'd1;
    else if (kmer_len_r > 6'(MAX_KMER_LENGTH)) k_eff = 6'(MAX_KMER_LENGTH);
    else k_eff = kmer_len_r;
    p_eff = (pfx_len_r > k_eff) ? k_eff : pfx_len_r;
  end

  assign cfg.k = k_eff;
  assign cfg.sh = {k_eff, 1'b0} - {p_eff, 1'b0};
  assign cfg.full = low_mask({k_eff, 1'b0});
  assign cfg.key = key_r & cfg.full;
  assign cfg.coeff = coeff_r;
  assign cfg.inv = inv_coeff;

  kbh_inv u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_wr && (cfg_index == REG_COEFF)),
    .coeff     (coeff_nxt),
    .busy      (inv_busy),
    .inv_coeff (inv_coeff)
  );

  kbh_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .hold            (inv_busy),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result      (out_result),
    .out_prefix_part (out_prefix_part),
    .out_suffix_part (out_suffix_part)
  );

  // no item enters while the inverse is being rebuilt
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    inv_busy |-> in_stall)
    else $error("input accepted while inverse unit busy");

  // a coefficient write always launches the inverse unit
  a_coeff_starts_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == REG_COEFF)) |=> !cfg_ready)
    else $error("coefficient write did not start inverse unit");

  // results never carry bits above 2k
  a_result_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result & ~cfg.full) == '0))
    else $error("result wider than 2k bits");

  // suffix stays within its field
  a_suffix_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_suffix_part & ~low_mask(cfg.sh)) == '0))
    else $error("suffix wider than its field");

endmodule

[rtl/core/kbh_inv.sv]
// Inverse of an odd coefficient mod 2^64 by Newton steps, one 32x32 product
// per cycle, three partial products accumulated per 64-bit product.
module kbh_inv import kbh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] coeff,
  output logic             busy,
  output logic [VAL_W-1:0] inv_coeff
);

  kbh_inv_state_t   state_r, state_nxt;
  logic [VAL_W-1:0] a_r, a_nxt;
  logic [VAL_W-1:0] x_r, x_nxt;
  logic [VAL_W-1:0] q_r, q_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [1:0]       pp_r, pp_nxt;
  logic             ph_r, ph_nxt;   // 0: a*x, 1: x*(2-a*x)
  logic [1:0]       it_r, it_nxt;

  logic [VAL_W-1:0] ma, mb;
  logic [HALF_W-1:0] op_l, op_r;
  logic [VAL_W-1:0] mprod;
  logic [VAL_W-1:0] seed;

  assign ma = ph_r ? x_r : a_r;
  assign mb = ph_r ? q_r : x_r;

  always_comb begin
    case (pp_r)
      2'd0: begin
        op_l = ma[HALF_W-1:0];
        op_r = mb[HALF_W-1:0];
      end
      2'd1: begin
        op_l = ma[VAL_W-1:HALF_W];
        op_r = mb[HALF_W-1:0];
      end
      default: begin
        op_l = ma[HALF_W-1:0];
        op_r = mb[VAL_W-1:HALF_W];
      end
    endcase
  end

  assign mprod = VAL_W'(op_l) * VAL_W'(op_r);
  assign seed = ((coeff << 1) + coeff) ^ VAL_W'(2);

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r;
    x_nxt = x_r;
    q_nxt = q_r;
    acc_nxt = acc_r;
    pp_nxt = pp_r;
    ph_nxt = ph_r;
    it_nxt = it_r;
    case (state_r)
      INV_IDLE: begin
        if (start) begin
          a_nxt = coeff;
          x_nxt = seed;
          pp_nxt = 2'd0;
          ph_nxt = 1'b0;
          it_nxt = 2'd0;
          state_nxt = INV_RUN;
        end
      end
      INV_RUN: begin
        if (pp_r == 2'd0) acc_nxt = mprod;
        else acc_nxt = acc_r + {mprod[HALF_W-1:0], {HALF_W{1'b0}}};
        if (pp_r == 2'd2) begin
          pp_nxt = 2'd0;
          if (!ph_r) begin
            q_nxt = VAL_W'(2) - acc_nxt;
            ph_nxt = 1'b1;
          end else begin
            x_nxt = acc_nxt;
            ph_nxt = 1'b0;
            it_nxt = it_r + 2'd1;
            if (it_r == 2'd3) state_nxt = INV_IDLE;
          end
        end else begin
          pp_nxt = pp_r + 2'd1;
        end
      end
      default: state_nxt = INV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= INV_IDLE;
      x_r <= VAL_W'(1);
      pp_r <= 2'd0;
      ph_r <= 1'b0;
      it_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      x_r <= x_nxt;
      pp_r <= pp_nxt;
      ph_r <= ph_nxt;
      it_r <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    q_r <= q_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = (state_r == INV_RUN);
  assign inv_coeff = x_r;

endmodule

[rtl/core/kbh_pipe.sv]
// Four-stage hash datapath: operand prep, partial products, sum and unswap,
// prefix/suffix split into the output register.
module kbh_pipe import kbh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  kbh_cfg_t         cfg,
  input  logic             hold,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_result,
  output logic [VAL_W-1:0] out_prefix_part,
  output logic [VAL_W-1:0] out_suffix_part
);

  logic en, take;

  logic             v1_r, v2_r, v3_r, vo_r;
  logic             a1_r, a2_r, a3_r;
  logic [VAL_W-1:0] op1_r, mc1_r;
  logic [VAL_W-1:0] pp0_r;
  logic [HALF_W-1:0] pp1_r, pp2_r;
  logic [VAL_W-1:0] r3_r;
  logic [VAL_W-1:0] res_r, pre_r, suf_r;

  logic [VAL_W-1:0] s_in, op_nxt, mc_nxt;
  logic [VAL_W-1:0] prod, r_nxt;
  logic [VAL_W-1:0] pre_nxt, suf_nxt;

  assign en = !(vo_r && out_stall);
  assign in_stall = !en || hold;
  assign take = in_valid && !in_stall;

  // stage 1
  assign s_in = in_value & cfg.full;
  assign op_nxt = (in_action == ACT_INVERSE) ? s_in
                : (swap_halves(s_in, cfg.k, cfg.full) ^ cfg.key);
  assign mc_nxt = (in_action == ACT_INVERSE) ? (cfg.inv & cfg.full) : cfg.coeff;

  // stage 3
  assign prod = (pp0_r + {pp1_r + pp2_r, {HALF_W{1'b0}}}) & cfg.full;
  assign r_nxt = (a2_r == ACT_INVERSE) ? swap_halves(prod ^ cfg.key, cfg.k, cfg.full)
               : prod;

  // stage 4
  assign pre_nxt = (a3_r == ACT_INVERSE) ? '0 : (r3_r >> cfg.sh);
  assign suf_nxt = (a3_r == ACT_INVERSE) ? '0 : (r3_r & low_mask(cfg.sh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_action;
      op1_r <= op_nxt;
      mc1_r <= mc_nxt;
      a2_r <= a1_r;
      pp0_r <= VAL_W'(op1_r[HALF_W-1:0]) * VAL_W'(mc1_r[HALF_W-1:0]);
      pp1_r <= HALF_W'(op1_r[VAL_W-1:HALF_W] * mc1_r[HALF_W-1:0]);
      pp2_r <= HALF_W'(op1_r[HALF_W-1:0] * mc1_r[VAL_W-1:HALF_W]);
      a3_r <= a2_r;
      r3_r <= r_nxt;
      res_r <= r3_r;
      pre_r <= pre_nxt;
      suf_r <= suf_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_result = res_r;
  assign out_prefix_part = pre_r;
  assign out_suffix_part = suf_r;

endmodule
